[rtl/font_unicode_table_parser_macros.svh]
// assertion macros used by the unicode table parser top level
// expects i_clk and i_rst_n in the scope of each use
`ifndef FONT_UNICODE_TABLE_PARSER_MACROS_SVH
`define FONT_UNICODE_TABLE_PARSER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FUTP_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("futp check failed");

// next-cycle implication, disabled while reset is asserted
`define FUTP_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("futp check failed");

`endif

[rtl/futp_pkg.sv]
// shared types and constants for the unicode table parser
// no dependencies
`default_nettype none

package futp_pkg;

    localparam int BYTE_W    = 8;
    localparam int CP_W      = 16;
    localparam int GLYPH_W   = 16;
    localparam int PEND_W    = 2;
    localparam int CONT_BITS = 6;

    // byte that closes a glyph's list when a lead byte is expected
    localparam logic [BYTE_W-1:0] GLYPH_END = 8'hFF;

    // pending continuation counts per sequence length
    localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
    localparam logic [PEND_W-1:0] PEND_TWO   = 2'd1;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd2;
    localparam logic [PEND_W-1:0] PEND_FOUR  = 2'd3;

    typedef struct packed {
        logic [GLYPH_W-1:0] glyph_counter;
        logic [PEND_W-1:0]  bytes_pending;
        logic [CP_W-1:0]    partial_code;
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [CP_W-1:0]    code_point;
        logic [GLYPH_W-1:0] glyph_index;
    } t_result;

endpackage

`default_nettype wire

[rtl/futp_decode.sv]
// single-byte utf-8 decode step: state and byte in, next state and result out
// depends on futp_pkg
`default_nettype none

module futp_decode (
    input  wire futp_pkg::t_state        i_state,
    input  wire [futp_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire                          i_first_of_table,
    output futp_pkg::t_state             o_state,
    output futp_pkg::t_result            o_result
);
    import futp_pkg::*;

    t_state              s_cur;
    logic [CP_W-1:0]     s_shifted;
    logic [PEND_W-1:0]   s_pend_dec;

    always_comb begin
        // a new table clears everything before the byte is looked at
        if (i_first_of_table) begin
            s_cur = '0;
        end else begin
            s_cur = i_state;
        end

        s_shifted  = {s_cur.partial_code[CP_W-CONT_BITS-1:0], i_byte_value[CONT_BITS-1:0]};
        s_pend_dec = s_cur.bytes_pending - PEND_TWO;

        o_state              = s_cur;
        o_result.valid       = 1'b0;
        o_result.code_point  = '0;
        o_result.glyph_index = s_cur.glyph_counter;

        if (s_cur.bytes_pending != PEND_NONE) begin
            // continuation, taken without checking its top bits
            o_state.bytes_pending = s_pend_dec;
            if (s_pend_dec != PEND_NONE) begin
                o_state.partial_code = s_shifted;
            end else begin
                o_state.partial_code = '0;
                o_result.valid       = 1'b1;
                o_result.code_point  = s_shifted;
            end
        end else if (i_byte_value == GLYPH_END) begin
            o_state.glyph_counter = s_cur.glyph_counter + GLYPH_W'(1);
        end else if (!i_byte_value[7]) begin
            o_result.valid      = 1'b1;
            o_result.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte_value};
        end else if (!i_byte_value[5]) begin
            o_state.partial_code  = {{(CP_W-5){1'b0}}, i_byte_value[4:0]};
            o_state.bytes_pending = PEND_TWO;
        end else if (!i_byte_value[4]) begin
            o_state.partial_code  = {{(CP_W-4){1'b0}}, i_byte_value[3:0]};
            o_state.bytes_pending = PEND_THREE;
        end else if (!i_byte_value[3]) begin
            o_state.partial_code  = {{(CP_W-3){1'b0}}, i_byte_value[2:0]};
            o_state.bytes_pending = PEND_FOUR;
        end else begin
            // lead bytes with bits 5..3 all set give code point zero
            o_result.valid = 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/font_unicode_table_parser.sv]
// top level of the unicode table parser: input register, decode, result register
// depends on futp_pkg, futp_decode and font_unicode_table_parser_macros.svh
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  input    | i_valid / o_ready  | i_byte_value, i_first_of_table
//  output   | o_valid / i_ready  | o_code_point, o_glyph_index
//
// one byte per cycle sustained while i_ready is high; each byte passes the input register, then the result register
// the decode between input register and result register is a few compares and a
// 16-bit increment, so the glyph/sequence state loop closes through r_state alone
// synchronous active-low reset clears valids and the decode state
// a stalled result holds both stages; o_ready drops only when both are full
// and the result is not being taken
`default_nettype none

module font_unicode_table_parser (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire [futp_pkg::BYTE_W-1:0]   i_byte_value,
    input  wire                          i_first_of_table,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [futp_pkg::CP_W-1:0]    o_code_point,
    output logic [futp_pkg::GLYPH_W-1:0] o_glyph_index
);
    import futp_pkg::*;

`include "font_unicode_table_parser_macros.svh"

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_first;

    // decode state carried from byte to byte
    t_state            r_state;
    t_state            n_state;

    // result register
    logic               r_out_valid;
    logic [CP_W-1:0]    r_out_code;
    logic [GLYPH_W-1:0] r_out_glyph;

    t_result           s_res;
    logic              s_advance;   // input stage moves into decode this cycle

    // result slot free or emptying, so the held byte can be decoded
    assign s_advance = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || s_advance;

    futp_decode u_decode (
        .i_state          (r_state),
        .i_byte_value     (r_in_byte),
        .i_first_of_table (r_in_first),
        .o_state          (n_state),
        .o_result         (s_res)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte  <= i_byte_value;
            r_in_first <= i_first_of_table;
        end
    end

    // decode state only moves when a byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (r_in_valid && s_advance) begin
            r_state <= n_state;
        end
    end

    // result stage; bytes with no result leave the slot empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_advance) begin
            r_out_valid <= r_in_valid && s_res.valid;
        end
        if (s_advance && r_in_valid && s_res.valid) begin
            r_out_code  <= s_res.code_point;
            r_out_glyph <= s_res.glyph_index;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_code_point  = r_out_code;
    assign o_glyph_index = r_out_glyph;

    // a byte that leaves a sequence open never produces a transaction
    `FUTP_ASSERT_NEXT(a_pending_no_result,
        r_in_valid && s_advance && (n_state.bytes_pending != PEND_NONE), !o_valid)

    // every emitted code point closes any sequence it belonged to
    `FUTP_ASSERT_NEXT(a_result_closes_seq,
        r_in_valid && s_advance && s_res.valid, r_state.bytes_pending == PEND_NONE)

    // continuations never touch the glyph counter
    `FUTP_ASSERT_NEXT(a_cont_keeps_glyph,
        r_in_valid && s_advance && !r_in_first && (r_state.bytes_pending != PEND_NONE),
        $stable(r_state.glyph_counter))

    // state is frozen unless a byte is consumed
    `FUTP_ASSERT_NEXT(a_state_idle_hold, !(r_in_valid && s_advance), $stable(r_state))

    // partial bits are cleared whenever no sequence is open
    `FUTP_ASSERT_NOW(a_partial_clear,
        r_state.bytes_pending == PEND_NONE, r_state.partial_code == '0)

endmodule

`default_nettype wire
